// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/wgle_pkg.sv =====
// Package with constants, codes and the exp2 factor function of the gamma table core.
`timescale 1ns / 1ps
package wgle_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_CENTER = 3'd0,
      CSR_WINDOW_WIDTH  = 3'd1,
      CSR_ENTRY_BITS    = 3'd2,
      CSR_GAMMA_INVERSE = 3'd3,
      CSR_BYTE_PACK     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FM_RANGE  = 2'd1,
      ST_WIDTH_LOW = 2'd2,
      ST_INDEX_OUT = 2'd3
   } status_type;

   localparam logic [17:0] RST_WINDOW_CENTER = 18'd128;
   localparam logic [15:0] RST_WINDOW_WIDTH  = 16'd256;
   localparam logic [4:0]  RST_ENTRY_BITS    = 5'd16;
   localparam logic [15:0] RST_GAMMA_INVERSE = 16'd4096;

   // Factor 2^(-2^-k) in Q31, found by k truncated square roots starting from 0.5.
   // Used only at elaboration.
   function automatic logic [31:0] exp_factor(input int k);
      logic [63:0] r;
      logic [63:0] v;
      logic [63:0] q;
      logic [63:0] b;
      r = 64'd1 << 30;
      for (int s = 0; s < k; s++) begin
         v = r << 31;
         q = '0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 64'd0) begin
            if (v >= q + b) begin
               v = v - (q + b);
               q = (q >> 1) + b;
            end else begin
               q = q >> 1;
            end
            b = b >> 2;
         end
         r = q;
      end
      return r[31:0];
   endfunction

endpackage

// ===== rtl/windowed_gamma_lut_entry_core.sv =====
// Top level of the gamma-shaped lookup table entry generator.
//
// Usage: the request channel (req_valid, req_stall, req_entry_index) carries one
// item per table entry index, or per packed word index when byte packing is on.
// The response channel (rsp_valid, rsp_stall and the rsp_ payload) returns one
// item per request, in order, with the entry value, the table descriptor words
// and a status code. The csr_ port writes the five configuration registers; it
// must only be used while no item is in flight.
// Throughput is one item per cycle while the receiver does not stall. Pipeline
// depth is set by the squaring chain of the log2 pipeline and the multiply chain
// of the exp2 pipeline, one bit per stage each. Reset clears every valid bit
// and loads the register defaults; the result pipeline needs no clearing pass.
// When the receiver stalls, the whole pipeline freezes with the output item
// held, and req_stall rises in the same cycle so no item is lost or repeated.
// Byte-pack mode runs two entry lanes side by side.
`timescale 1ns / 1ps
module windowed_gamma_lut_entry_core
   import wgle_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [15:0]           req_entry_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_entry_value,
   output logic [15:0]           rsp_entry_count,
   output logic [15:0]           rsp_first_mapped,
   output logic [1:0]            rsp_status,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

`include "assert_macros.svh"

   localparam int LW = FRAC_BITS + 4;     // log2 width
   localparam int MW = FRAC_BITS + 8;     // scaled exponent width
   localparam int NS = 2 * FRAC_BITS + 6; // sideband stages

   // Per-item control that travels alongside the arithmetic lanes.
   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [15:0] fm_pat;
      logic        zero_lo;
      logic        zero_hi;
   } side_type;

   // Configuration registers.
   logic [17:0] center_ff;
   logic [15:0] width_ff;
   logic [4:0]  bits_ff;
   logic [15:0] ginv_ff;
   logic        pack_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= RST_WINDOW_CENTER;
         width_ff  <= RST_WINDOW_WIDTH;
         bits_ff   <= RST_ENTRY_BITS;
         ginv_ff   <= RST_GAMMA_INVERSE;
         pack_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_CENTER: center_ff <= csr_data;
            CSR_WINDOW_WIDTH:  width_ff  <= csr_data[15:0];
            CSR_ENTRY_BITS:    bits_ff   <= csr_data[4:0];
            CSR_GAMMA_INVERSE: ginv_ff   <= csr_data[15:0];
            CSR_BYTE_PACK:     pack_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves whenever the output register can take a new item.
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Entry stage: first mapped value, status and lane indexes.
   localparam logic signed [18:0] FM_LOW  = -19'sd32768;
   localparam logic signed [18:0] FM_HIGH = 19'sd65535;

   logic signed [19:0] diff;
   logic signed [19:0] diff_adj;
   logic signed [18:0] fm;
   logic [16:0]        words;
   logic [16:0]        hi_index;
   logic [15:0]        lo_idx;
   side_type           side_in;

   always_comb begin
      // Truncating halve toward zero: add one before the shift when negative.
      diff     = $signed({center_ff[17], center_ff, 1'b0}) - $signed({4'b0, width_ff});
      diff_adj = diff + {19'd0, diff[19]};
      fm       = diff_adj[19:1];
      words    = ({1'b0, width_ff} + 17'd1) >> 1;
      hi_index = {req_entry_index, 1'b1};
      lo_idx   = pack_ff ? {req_entry_index[14:0], 1'b0} : req_entry_index;

      side_in.valid   = req_valid;
      side_in.fm_pat  = fm[15:0];
      side_in.zero_lo = (lo_idx == 16'd0);
      side_in.zero_hi = !pack_ff || (hi_index >= {1'b0, width_ff});
      if (fm < FM_LOW || fm > FM_HIGH) begin
         side_in.status = ST_FM_RANGE;
         side_in.fm_pat = '0;
      end else if (width_ff < 16'd2) begin
         side_in.status = ST_WIDTH_LOW;
      end else if (pack_ff ? ({1'b0, req_entry_index} >= words)
                           : (req_entry_index >= width_ff)) begin
         side_in.status = ST_INDEX_OUT;
      end else begin
         side_in.status = ST_OK;
      end
   end

   side_type    side_ff [NS];
   logic [15:0] lo_idx_ff;
   logic [15:0] hi_idx_ff;
   logic [15:0] n1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NS; j++) side_ff[j].valid <= 1'b0;
      end else if (adv) begin
         side_ff[0] <= side_in;
         for (int j = 1; j < NS; j++) side_ff[j] <= side_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_idx_ff <= lo_idx;
         hi_idx_ff <= hi_index[15:0];
         n1_ff     <= width_ff - 16'd1;
      end
   end

   // Three log2 lanes: table span, low entry and high entry.
   logic [LW-1:0] log_n1;
   logic [LW-1:0] log_lo;
   logic [LW-1:0] log_hi;

   wgle_log2_pipe #(.FRAC_BITS(FRAC_BITS)) u_log_n1 (
      .clock(clock), .adv(adv), .value(n1_ff), .log_value(log_n1));
   wgle_log2_pipe #(.FRAC_BITS(FRAC_BITS)) u_log_lo (
      .clock(clock), .adv(adv), .value(lo_idx_ff), .log_value(log_lo));
   wgle_log2_pipe #(.FRAC_BITS(FRAC_BITS)) u_log_hi (
      .clock(clock), .adv(adv), .value(hi_idx_ff), .log_value(log_hi));

   // Distance in log domain, clamped at zero, then scaled by 1/gamma.
   logic [LW-1:0]    m_lo_ff;
   logic [LW-1:0]    m_hi_ff;
   logic [MW-1:0]    mg_lo_ff;
   logic [MW-1:0]    mg_hi_ff;
   logic [LW+15:0]   sc_lo;
   logic [LW+15:0]   sc_hi;

   assign sc_lo = m_lo_ff * ginv_ff;
   assign sc_hi = m_hi_ff * ginv_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m_lo_ff  <= (log_n1 > log_lo) ? log_n1 - log_lo : '0;
         m_hi_ff  <= (log_n1 > log_hi) ? log_n1 - log_hi : '0;
         mg_lo_ff <= sc_lo[LW+15:12];
         mg_hi_ff <= sc_hi[LW+15:12];
      end
   end

   logic [31:0] pow_lo;
   logic [31:0] pow_hi;

   wgle_exp2_pipe #(.FRAC_BITS(FRAC_BITS)) u_exp_lo (
      .clock(clock), .adv(adv), .mg(mg_lo_ff), .pow(pow_lo));
   wgle_exp2_pipe #(.FRAC_BITS(FRAC_BITS)) u_exp_hi (
      .clock(clock), .adv(adv), .mg(mg_hi_ff), .pow(pow_hi));

   // Scale by the entry maximum; entry bits saturate to the 8..16 range.
   logic [4:0]  bits_sat;
   logic [15:0] maxv;
   logic [47:0] prod_lo;
   logic [47:0] prod_hi;
   logic [15:0] val_lo_ff;
   logic [15:0] val_hi_ff;

   always_comb begin
      if (bits_ff < 5'd8)       bits_sat = 5'd8;
      else if (bits_ff > 5'd16) bits_sat = 5'd16;
      else                      bits_sat = bits_ff;
      maxv    = pack_ff ? 16'd255 : (16'hFFFF >> (5'd16 - bits_sat));
      prod_lo = maxv * pow_lo;
      prod_hi = maxv * pow_hi;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         val_lo_ff <= prod_lo[46:31];
         val_hi_ff <= prod_hi[46:31];
      end
   end

   // Output register: status override, zero entries and byte packing.
   side_type    last;
   logic [15:0] lo_v;
   logic [15:0] hi_v;
   logic [15:0] value_in;
   logic [15:0] value_ff;
   logic [15:0] count_ff;
   logic [15:0] fm_ff;
   logic [1:0]  status_ff;

   always_comb begin
      last = side_ff[NS-1];
      lo_v = last.zero_lo ? 16'd0 : val_lo_ff;
      hi_v = last.zero_hi ? 16'd0 : val_hi_ff;
      if (last.status != ST_OK)  value_in = '0;
      else if (pack_ff)          value_in = {hi_v[7:0], lo_v[7:0]};
      else                       value_in = lo_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         value_ff  <= value_in;
         count_ff  <= width_ff;
         fm_ff     <= last.fm_pat;
         status_ff <= last.status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_value  = value_ff;
   assign rsp_entry_count  = count_ff;
   assign rsp_first_mapped = fm_ff;
   assign rsp_status       = status_ff;

   // Any error status carries a zero entry.
   `ASSERT_IMPLIES(a_err_zero, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_entry_value == 16'd0)
   // An out-of-range first mapped value is reported as zero.
   `ASSERT_IMPLIES(a_fm_zero, clock, reset, rsp_valid && rsp_status == ST_FM_RANGE, rsp_first_mapped == 16'd0)
   // Backpressure only comes from a held output item.
   `ASSERT_IMPLIES(a_stall_src, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

// ===== rtl/wgle_log2_pipe.sv =====
// Pipelined fixed-point log2: one normalize stage, then one squaring stage per fraction bit.
`timescale 1ns / 1ps
module wgle_log2_pipe
   import wgle_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   adv,
   input  logic [15:0]            value,
   output logic [FRAC_BITS+3:0]   log_value
);

   localparam int RW = FRAC_BITS + 4;

   logic [FRAC_BITS:0]   z_ff   [FRAC_BITS+1];
   logic [RW-1:0]        res_ff [FRAC_BITS+1];

   logic [3:0]            msb;
   logic [15+FRAC_BITS:0] vshift;

   always_comb begin
      msb = '0;
      for (int b = 0; b < 16; b++) begin
         if (value[b]) msb = 4'(b);
      end
      vshift = {value, {FRAC_BITS{1'b0}}} >> msb;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z_ff[0]   <= vshift[FRAC_BITS:0];
         res_ff[0] <= {msb, {FRAC_BITS{1'b0}}};
      end
   end

   // Each squaring yields one fraction bit, most significant first.
   for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_sq
      logic [2*FRAC_BITS+1:0] sq;
      logic [FRAC_BITS+1:0]   zz;
      logic [FRAC_BITS:0]     z_in;
      logic [RW-1:0]          res_in;
      always_comb begin
         sq     = z_ff[j-1] * z_ff[j-1];
         zz     = sq[2*FRAC_BITS+1:FRAC_BITS];
         res_in = res_ff[j-1];
         if (zz[FRAC_BITS+1]) begin
            z_in                    = zz[FRAC_BITS+1:1];
            res_in[FRAC_BITS-j]     = 1'b1;
         end else begin
            z_in = zz[FRAC_BITS:0];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            z_ff[j]   <= z_in;
            res_ff[j] <= res_in;
         end
      end
   end

   assign log_value = res_ff[FRAC_BITS];

endmodule

// ===== rtl/wgle_exp2_pipe.sv =====
// Pipelined 2^-x in Q31: one multiply stage per fraction bit, then the integer shift.
`timescale 1ns / 1ps
module wgle_exp2_pipe
   import wgle_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic [FRAC_BITS+7:0] mg,
   output logic [31:0]          pow
);

   localparam int MW = FRAC_BITS + 8;

   logic [31:0]   acc_ff [FRAC_BITS];
   logic [MW-1:0] mg_ff  [FRAC_BITS];
   logic [31:0]   pow_ff;

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_mul
      localparam logic [31:0] FACT = exp_factor(k + 1);
      logic [31:0]   acc_prev;
      logic [MW-1:0] mg_prev;
      logic [63:0]   prod;
      if (k == 0) begin : g_first
         assign acc_prev = 32'h8000_0000;
         assign mg_prev  = mg;
      end else begin : g_next
         assign acc_prev = acc_ff[k-1];
         assign mg_prev  = mg_ff[k-1];
      end
      assign prod = acc_prev * FACT;
      always_ff @(posedge clock) begin
         if (adv) begin
            acc_ff[k] <= mg_prev[FRAC_BITS-1-k] ? prod[62:31] : acc_prev;
            mg_ff[k]  <= mg_prev;
         end
      end
   end

   logic [7:0] ip;
   assign ip = mg_ff[FRAC_BITS-1][MW-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (adv) begin
         pow_ff <= (ip >= 8'd32) ? 32'd0 : (acc_ff[FRAC_BITS-1] >> ip[4:0]);
      end
   end

   assign pow = pow_ff;

endmodule

// ===== tb/wgle_checker.sv =====
// Checker for the gamma table core: mirrors the registers, predicts each entry and compares.
`timescale 1ns / 1ps
module wgle_checker
   import wgle_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [15:0]           req_entry_index,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [15:0]           rsp_entry_value,
   input  logic [15:0]           rsp_entry_count,
   input  logic [15:0]           rsp_first_mapped,
   input  logic [1:0]            rsp_status,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending_count
);

   localparam int FB = FRAC_BITS_DEF;

   typedef struct packed {
      logic [15:0] value;
      logic [15:0] count;
      logic [15:0] first;
      status_type  status;
   } lut_word_type;

   logic [17:0]  center_q;
   logic [15:0]  width_q;
   logic [4:0]   bits_q;
   logic [15:0]  ginv_q;
   logic         pack_q;
   lut_word_type expected_words[$];

   assign pending_count = expected_words.size();

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] b;
      root = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // Truncated log2 in Q.FB, one fraction bit per squaring.
   function automatic logic [63:0] log2_fixed(input logic [63:0] v);
      logic [63:0] e;
      logic [63:0] z;
      logic [63:0] acc;
      e = 0;
      while ((v >> (e + 1)) != 0) e++;
      z = (v << FB) >> e;
      acc = e << FB;
      for (int b = FB - 1; b >= 0; b--) begin
         z = (z * z) >> FB;
         if (z >= (64'd2 << FB)) begin
            z = z >> 1;
            acc[b] = 1'b1;
         end
      end
      return acc;
   endfunction

   // 2^-mg in Q31.
   function automatic logic [63:0] pow2_neg(input logic [63:0] mg);
      logic [63:0] ip;
      logic [63:0] acc;
      logic [63:0] r;
      ip = mg >> FB;
      acc = 64'd1 << 31;
      r = 64'd1 << 30;
      if (ip >= 32) return 0;
      for (int k = 1; k <= FB; k++) begin
         r = int_sqrt(r << 31);
         if (mg[FB-k]) acc = (acc * r) >> 31;
      end
      return acc >> ip;
   endfunction

   function automatic logic [63:0] gamma_entry(input logic [63:0] i, input logic [63:0] n,
                                               input logic [63:0] maxv);
      logic [63:0] la;
      logic [63:0] lb;
      logic [63:0] m;
      if (i == 0) return 0;
      la = log2_fixed(n - 1);
      lb = log2_fixed(i);
      m = (la > lb) ? la - lb : 0;
      return (maxv * pow2_neg((m * ginv_q) >> 12)) >> 31;
   endfunction

   function automatic lut_word_type predict_word(input logic [15:0] idx);
      lut_word_type w;
      longint       ctr;
      longint       fm;
      logic [63:0]  n;
      logic [63:0]  lo;
      logic [63:0]  hi;
      int           nb;
      n = width_q;
      ctr = longint'(signed'(center_q));
      fm = (2 * ctr - longint'(n)) / 2;
      w.value = '0;
      w.count = width_q;
      w.first = '0;
      w.status = ST_OK;
      if (fm < -32768 || fm > 65535) begin
         w.status = ST_FM_RANGE;
      end else begin
         w.first = fm[15:0];
         if (n < 2) begin
            w.status = ST_WIDTH_LOW;
         end else if (pack_q) begin
            if (idx >= (n + 1) / 2) begin
               w.status = ST_INDEX_OUT;
            end else begin
               lo = gamma_entry(2 * idx, n, 255);
               hi = (2 * idx + 1 < n) ? gamma_entry(2 * idx + 1, n, 255) : 0;
               w.value = {hi[7:0], lo[7:0]};
            end
         end else begin
            nb = bits_q;
            if (nb < 8) nb = 8;
            if (nb > 16) nb = 16;
            if (idx >= n) w.status = ST_INDEX_OUT;
            else w.value = 16'(gamma_entry(idx, n, 64'hFFFF >> (16 - nb)));
         end
      end
      return w;
   endfunction

   task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      lut_word_type w;
      if (reset) begin
         center_q <= RST_WINDOW_CENTER;
         width_q <= RST_WINDOW_WIDTH;
         bits_q <= RST_ENTRY_BITS;
         ginv_q <= RST_GAMMA_INVERSE;
         pack_q <= 1'b0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) expected_words.push_back(predict_word(req_entry_index));
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("unexpected result item at %0t", $realtime);
               fail_count++;
            end else begin
               w = expected_words.pop_front();
               if (rsp_entry_value !== w.value) report("entry_value", rsp_entry_value, w.value);
               if (rsp_entry_count !== w.count) report("entry_count", rsp_entry_count, w.count);
               if (rsp_first_mapped !== w.first) report("first_mapped", rsp_first_mapped, w.first);
               if (rsp_status !== w.status)
                  report("status", 16'(rsp_status), 16'(w.status));
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_WINDOW_CENTER: center_q <= csr_data[17:0];
               CSR_WINDOW_WIDTH:  width_q <= csr_data[15:0];
               CSR_ENTRY_BITS:    bits_q <= csr_data[4:0];
               CSR_GAMMA_INVERSE: ginv_q <= csr_data[15:0];
               CSR_BYTE_PACK:     pack_q <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the gamma table core: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module tb;
   import wgle_pkg::*;

   // Settle margins are taken a little wider than the core's latency.
   localparam int SETTLE_CYCLES = 50;
   localparam int CYCLE_LIMIT   = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [15:0]           req_entry_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [15:0]           rsp_entry_value;
   logic [15:0]           rsp_entry_count;
   logic [15:0]           rsp_first_mapped;
   logic [1:0]            rsp_status;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   bit steady = 0;

   // Shadow copies of width and packing, used only to aim the indices.
   int  cur_width = 256;
   bit  cur_pack = 0;

   always #5 clock = ~clock;

   windowed_gamma_lut_entry_core u_top (.*);

   wgle_checker u_checker (.*);

   // The receiver stalls about a quarter of the time, except in the steady stretch.
   always @(posedge clock) begin
      rsp_stall <= steady ? 1'b0 : ($urandom_range(99) < 26);
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stops offering items, waits until every expected result has come back,
   // then lets the pipe settle.
   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // Writes all five registers; the block must be idle when this is called.
   task automatic load_window(input int center, input int width, input int nbits,
                              input int ginv, input bit pack);
      drain_pipe();
      write_reg(CSR_WINDOW_CENTER, center[17:0]);
      write_reg(CSR_WINDOW_WIDTH, width[17:0]);
      write_reg(CSR_ENTRY_BITS, nbits[17:0]);
      write_reg(CSR_GAMMA_INVERSE, ginv[17:0]);
      write_reg(CSR_BYTE_PACK, {17'd0, pack});
      cur_width = width & 16'hFFFF;
      cur_pack = pack;
   endtask

   // Offers one item and holds it until the core takes it. The valid is only
   // lowered on idle cycles, so it never drops and rises within one step.
   task automatic send_index(input logic [15:0] idx);
      while (!steady && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_entry_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Mostly indices inside the table, now and then any 16-bit value.
   task automatic send_random(input int count);
      int top;
      top = cur_pack ? (cur_width + 1) / 2 - 1 : cur_width - 1;
      for (int k = 0; k < count; k++) begin
         if (top < 1 || $urandom_range(9) == 0) send_index(16'($urandom_range(16'hFFFF)));
         else send_index(16'($urandom_range(top)));
      end
   endtask

   initial begin
      int c;
      int w;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items under the reset values: first, middle and last entries, the
      // index just past the table, the all-ones index and two alternating-bit indices.
      send_index(16'd0);
      send_index(16'd1);
      send_index(16'd128);
      send_index(16'd254);
      send_index(16'd255);
      send_index(16'd256);
      send_index(16'hFFFF);
      send_index(16'h5555);
      send_index(16'hAAAA);

      // Width below two, first mapped value beyond both ends of its range.
      load_window(0, 0, 16, 4096, 0);
      send_index(16'd0);
      load_window(5, 1, 16, 4096, 0);
      send_index(16'd0);
      load_window(-65536, 65535, 16, 4096, 0);
      send_index(16'd3);
      load_window(131071, 0, 16, 4096, 0);
      send_index(16'd0);

      // Zero inverse gamma, entry bits below and above their range, odd packed table.
      load_window(100, 9, 16, 0, 0);
      send_index(16'd0);
      send_index(16'd4);
      send_index(16'd8);
      load_window(100, 9, 0, 4096, 0);
      send_index(16'd8);
      load_window(100, 9, 31, 4096, 0);
      send_index(16'd8);
      load_window(100, 9, 8, 4096, 1);
      send_index(16'd0);
      send_index(16'd4);
      send_index(16'd5);

      // Fixed corner settings, the steady stretch among them.
      load_window(32768, 65535, 16, 65535, 0);
      send_random(60);
      load_window(-32768, 2, 8, 1, 1);
      send_random(60);
      steady = 1;
      load_window(2000, 4096, 12, 2731, 0);
      send_random(150);
      steady = 0;
      load_window(-65535, 65535, 16, 12288, 1);
      send_random(60);
      load_window(65535, 65535, 10, 4096, 0);
      send_random(60);
      load_window(300, 3, 16, 8192, 1);
      send_random(40);

      // Random settings, mostly with the first mapped value in range.
      for (int p = 0; p < 11; p++) begin
         c = $urandom_range(800) - 300;
         w = ($urandom_range(5) == 0) ? $urandom_range(65535) : $urandom_range(600);
         if ($urandom_range(7) == 0) c = $urandom_range(18'h3FFFF);
         load_window(c, w, $urandom_range(20, 6),
                     ($urandom_range(3) == 0) ? $urandom_range(65535)
                                              : $urandom_range(12000, 1000),
                     $urandom_range(1));
         send_random(80);
      end

      req_valid <= 1'b0;
      drain_pipe();
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wgle_pkg.sv
rtl/wgle_log2_pipe.sv
rtl/wgle_exp2_pipe.sv
rtl/windowed_gamma_lut_entry_core.sv
tb/wgle_checker.sv
tb/tb.sv
